// ===== src/first_fit_heap_allocator_top_defines.svh =====
// Assertion macros for the first-fit heap allocator.
// Used by first_fit_heap_allocator_top; depends on nothing else.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked every clock edge, off during reset.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked against the following edge.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ffa_pkg.sv =====
// Shared constants, types and helpers of the first-fit heap allocator.
// No dependencies.
package ffa_pkg;

  localparam int unsigned ARENA_MAX_BYTES = 65536;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned GRANULE_BYTES   = 8;
  localparam int unsigned HDR = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES
                                * GRANULE_BYTES;
  localparam int unsigned DEPTH   = ARENA_MAX_BYTES / GRANULE_BYTES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned G_SHIFT = $clog2(GRANULE_BYTES);

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_COLLECT = 2'd2;
  localparam logic [1:0] FUNC_SPRAY   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;

  typedef struct packed {
    logic              start;
    logic              used;
    logic [SIZE_W-1:0] size;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Round up to a granule and clamp into the legal arena range.
  function automatic logic [SIZE_W-1:0] effective_arena(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] a;
    a = ({1'b0, v} + (SIZE_W+1)'(GRANULE_BYTES - 1)) & ~(SIZE_W+1)'(GRANULE_BYTES - 1);
    if (a > (SIZE_W+1)'(ARENA_MAX_BYTES))
      a = (SIZE_W+1)'(ARENA_MAX_BYTES);
    if (a < (SIZE_W+1)'(HDR + 8))
      a = (SIZE_W+1)'(HDR + 8);
    return a[SIZE_W-1:0];
  endfunction

endpackage

// ===== src/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator top level: sequencer, chunk walker and result register.
// Depends on ffa_pkg, ffa_ram and first_fit_heap_allocator_top_defines.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | func, request_bytes, payload_offset
//   out_    | output    | out_valid/out_stall| result_offset, status, spray_flag
//   cfg_    | input     | cfg_valid/cfg_ready| arena_bytes
//
// Allocate, free and collect walk the chunk headers through one single-port table;
// merge walks follow free and collect. After reset and after every arena_bytes write
// the table is swept with in_stall high; in_stall is also high while cfg_valid is.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken.
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [19:0]               in_request_bytes,
  input  logic [15:0]               in_payload_offset,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [15:0]               out_result_offset,
  output logic [1:0]                out_status,
  output logic                      out_spray_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ffa_pkg::SIZE_W-1:0] cfg_arena_bytes
);
  import ffa_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RES,
    A_RD, A_CHK, A_SPL, A_WR,
    F_RD, F_CHK, F_WR,
    M_RD, M_LD, M_CHK, M_NX, M_CLR,
    C_RD, C_CHK,
    P_RD, P_CHK
  } state_t;

  state_t              state_r;
  logic [SIZE_W-1:0]   arena_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [SIZE_W-1:0]   cur_r;
  logic [SIZE_W-1:0]   nx_r;
  logic [SIZE_W-1:0]   cur_size_r;
  logic                cur_use_r;
  logic [SIZE_W-1:0]   split_size_r;
  logic [ADDR_W-1:0]   g_r;
  logic [ADDR_W-1:0]   ng_r;
  logic [20:0]         need_r;
  logic [15:0]         res_off_r;
  logic [1:0]          res_st_r;
  logic                res_spray_r;
  logic                out_valid_r;
  logic [15:0]         out_off_r;
  logic [1:0]          out_st_r;
  logic                out_spray_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  entry_t              ram_wdata;
  entry_t              ram_q;

  ffa_ram #(.DEPTH_P(DEPTH), .WIDTH_P(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  logic              in_xfer, out_xfer, cfg_xfer;
  logic [15:0]       h_off;
  logic              off_bad;
  logic [20:0]       need_in;
  logic [17:0]       walk_nx;
  logic [17:0]       merge_nx;
  logic [SIZE_W-1:0] merged_size;
  logic [20:0]       split_end;
  logic              fits;
  logic              do_split;

  // A pending register write wins over an input transfer in the same cycle.
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_xfer  = out_valid_r && !out_stall;

  assign out_valid         = out_valid_r;
  assign out_result_offset = out_off_r;
  assign out_status        = out_st_r;
  assign out_spray_flag    = out_spray_r;

  // Header granule named by a payload offset; null, below a header, misaligned or past the arena is bad.
  assign h_off   = in_payload_offset - 16'(HDR);
  assign off_bad = (in_payload_offset < 16'(HDR)) || (h_off[G_SHIFT-1:0] != '0) ||
                   ({1'b0, h_off} >= arena_r);
  assign need_in = ({1'b0, in_request_bytes} + 21'(GRANULE_BYTES - 1)) &
                   ~21'(GRANULE_BYTES - 1);

  assign walk_nx     = {1'b0, cur_r} + 18'(HDR) + {1'b0, ram_q.size};
  assign merge_nx    = {1'b0, cur_r} + 18'(HDR) + {1'b0, cur_size_r};
  assign merged_size = cur_size_r + SIZE_W'(HDR) + ram_q.size;
  assign split_end   = {4'd0, cur_r} + 21'(HDR) + need_r;
  assign fits        = !ram_q.used && ({4'd0, ram_q.size} >= need_r);
  assign do_split    = ({5'd0, ram_q.size} >= ({1'b0, need_r} + 22'(HDR + 8)));

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_r[ADDR_W+G_SHIFT-1:G_SHIFT];
    ram_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        if (clr_cnt_r == '0)
          ram_wdata = '{start: 1'b1, used: 1'b0, size: arena_r - SIZE_W'(HDR)};
      end
      A_SPL: begin
        ram_we    = 1'b1;
        ram_addr  = ng_r;
        ram_wdata = '{start: 1'b1, used: 1'b0, size: split_size_r};
      end
      A_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{start: 1'b1, used: 1'b1, size: cur_size_r};
      end
      F_RD, P_RD: ram_addr = g_r;
      F_WR: begin
        ram_we    = 1'b1;
        ram_addr  = g_r;
        ram_wdata = '{start: 1'b1, used: 1'b0, size: cur_size_r};
      end
      M_CHK: ram_addr = merge_nx[ADDR_W+G_SHIFT-1:G_SHIFT];
      M_NX: begin
        ram_we    = !cur_use_r && !ram_q.used;
        ram_wdata = '{start: 1'b1, used: 1'b0, size: merged_size};
      end
      M_CLR: begin
        ram_we   = 1'b1;
        ram_addr = ng_r;
      end
      C_CHK: begin
        ram_we    = ram_q.used && (ram_q.size == '0);
        ram_wdata = '{start: 1'b1, used: 1'b0, size: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      arena_r     <= effective_arena(SIZE_W'(ARENA_MAX_BYTES));
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_RES loads the output register itself, so the clear stays out of its way.
      if (out_xfer && (state_r != S_RES))
        out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1))
            state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_xfer) begin
            arena_r   <= effective_arena(cfg_arena_bytes);
            clr_cnt_r <= '0;
            state_r   <= S_CLR;
          end else if (in_xfer) begin
            res_off_r   <= '0;
            res_st_r    <= ST_OK;
            res_spray_r <= 1'b0;
            cur_r       <= '0;
            need_r      <= need_in;
            g_r         <= h_off[ADDR_W+G_SHIFT-1:G_SHIFT];
            unique case (in_func)
              FUNC_ALLOC: begin
                if (in_request_bytes == '0) begin
                  res_st_r <= ST_INVAL;
                  state_r  <= S_RES;
                end else begin
                  state_r <= A_RD;
                end
              end
              FUNC_FREE: begin
                if (off_bad) begin
                  res_st_r <= ST_INVAL;
                  state_r  <= S_RES;
                end else begin
                  state_r <= F_RD;
                end
              end
              FUNC_COLLECT: state_r <= C_RD;
              FUNC_SPRAY: begin
                if (in_payload_offset == '0) begin
                  state_r <= S_RES;
                end else if (off_bad) begin
                  res_st_r <= ST_INVAL;
                  state_r  <= S_RES;
                end else begin
                  state_r <= P_RD;
                end
              end
              default: state_r <= S_RES;
            endcase
          end
        end
        A_RD: state_r <= A_CHK;
        A_CHK: begin
          if (fits) begin
            if (do_split) begin
              split_size_r <= ram_q.size - need_r[SIZE_W-1:0] - SIZE_W'(HDR);
              ng_r         <= split_end[ADDR_W+G_SHIFT-1:G_SHIFT];
              cur_size_r   <= need_r[SIZE_W-1:0];
              state_r      <= A_SPL;
            end else begin
              cur_size_r <= ram_q.size;
              state_r    <= A_WR;
            end
          end else if (walk_nx >= {1'b0, arena_r}) begin
            res_st_r <= ST_NOMEM;
            state_r  <= S_RES;
          end else begin
            cur_r   <= walk_nx[SIZE_W-1:0];
            state_r <= A_RD;
          end
        end
        A_SPL: state_r <= A_WR;
        A_WR: begin
          res_off_r <= cur_r[15:0] + 16'(HDR);
          state_r   <= S_RES;
        end
        F_RD: state_r <= F_CHK;
        F_CHK: begin
          if (ram_q.start && ram_q.used) begin
            cur_size_r <= ram_q.size;
            state_r    <= F_WR;
          end else begin
            res_st_r <= ST_INVAL;
            state_r  <= S_RES;
          end
        end
        F_WR: begin
          cur_r   <= '0;
          state_r <= M_RD;
        end
        M_RD: state_r <= M_LD;
        M_LD: begin
          cur_size_r <= ram_q.size;
          cur_use_r  <= ram_q.used;
          state_r    <= M_CHK;
        end
        M_CHK: begin
          if (merge_nx >= {1'b0, arena_r}) begin
            state_r <= S_RES;
          end else begin
            nx_r    <= merge_nx[SIZE_W-1:0];
            state_r <= M_NX;
          end
        end
        M_NX: begin
          if (!cur_use_r && !ram_q.used) begin
            cur_size_r <= merged_size;
            ng_r       <= nx_r[ADDR_W+G_SHIFT-1:G_SHIFT];
            state_r    <= M_CLR;
          end else begin
            cur_r      <= nx_r;
            cur_size_r <= ram_q.size;
            cur_use_r  <= ram_q.used;
            state_r    <= M_CHK;
          end
        end
        M_CLR: state_r <= M_CHK;
        C_RD: state_r <= C_CHK;
        C_CHK: begin
          if (walk_nx >= {1'b0, arena_r}) begin
            cur_r   <= '0;
            state_r <= M_RD;
          end else begin
            cur_r   <= walk_nx[SIZE_W-1:0];
            state_r <= C_RD;
          end
        end
        P_RD: state_r <= P_CHK;
        P_CHK: begin
          if (!ram_q.start)
            res_st_r <= ST_INVAL;
          else
            res_spray_r <= (ram_q.size > (arena_r >> 1));
          state_r <= S_RES;
        end
        S_RES: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_off_r   <= res_off_r;
            out_st_r    <= res_st_r;
            out_spray_r <= res_spray_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT_NEXT(a_busy_after_take, in_xfer, in_stall, "took an item without going busy")
  `FFA_ASSERT_IMP(a_offset_means_ok, out_valid_r && (out_off_r != '0), out_st_r == ST_OK, "offset with a failure status")
  `FFA_ASSERT_IMP(a_spray_means_ok, out_valid_r && out_spray_r, (out_st_r == ST_OK) && (out_off_r == '0), "spray flag with bad status")

endmodule

// ===== src/ffa_ram.sv =====
// Single-port chunk table: one read or write per cycle, registered read data.
// Depends on nothing.
module ffa_ram #(
  parameter int unsigned DEPTH_P = 8192,
  parameter int unsigned WIDTH_P = 19
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] addr,
  input  logic [WIDTH_P-1:0]         wdata,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we)
      mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
